### src/masked_laplacian_sharpen_unit_defines.svh
// Assertion macros shared by the masked Laplacian sharpening unit.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef MASKED_LAPLACIAN_SHARPEN_UNIT_DEFINES_SVH
`define MASKED_LAPLACIAN_SHARPEN_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MLS_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mls: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define MLS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mls: next-cycle check failed");

`endif

### src/mls_pkg.sv
// Shared constants, register codes and stage types of the masked Laplacian sharpening unit.
// No dependencies; every source file but the assertion header imports it.
package mls_pkg;

    // default geometry limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // field widths
    localparam int PIX_W      = 8;
    localparam int ENTRY_W    = PIX_W + 1;   // mask bit over the grey level
    localparam int XY_W       = 10;
    localparam int AMOUNT_W   = 12;
    localparam int GEOM_W     = 11;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_ADDR_W = 2;

    // stream packing
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - PIX_W - 2 * XY_W;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GEOM_COLS      = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_GEOM_ROWS      = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_SHARPEN_AMOUNT = CFG_ADDR_W'(2);

    // configuration reset values
    localparam logic [GEOM_W-1:0]   RST_GEOM_COLS      = GEOM_W'(640);
    localparam logic [GEOM_W-1:0]   RST_GEOM_ROWS      = GEOM_W'(480);
    localparam logic [AMOUNT_W-1:0] RST_SHARPEN_AMOUNT = AMOUNT_W'(128);

    // result slots of one input pixel, in emission order
    localparam int NUM_SLOTS = 3;
    localparam int SLOT_W    = 2;
    localparam logic [SLOT_W-1:0] SLOT_A = SLOT_W'(0);  // pixel above the input
    localparam logic [SLOT_W-1:0] SLOT_B = SLOT_W'(1);  // last row, left of the input
    localparam logic [SLOT_W-1:0] SLOT_C = SLOT_W'(2);  // last row, the input itself

    // operands of one sharpened pixel, neighbours already resolved
    typedef struct packed {
        logic [ENTRY_W-1:0] center;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   right;
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   bottom;
        logic [XY_W-1:0]    x;
        logic [XY_W-1:0]    y;
    } mls_job_t;

    // everything one input pixel releases
    typedef struct packed {
        logic [NUM_SLOTS-1:0]            mask;
        mls_job_t [NUM_SLOTS-1:0]        job;
    } mls_bundle_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [XY_W-1:0]  x;
        logic [XY_W-1:0]  y;
    } mls_result_t;

    typedef logic [NUM_SLOTS-1:0][PIX_W-1:0] mls_pixels_t;

endpackage

### src/masked_laplacian_sharpen_unit.sv
// Top level of the masked 3x3 Laplacian sharpening unit: configuration registers,
// line window, three sharpening datapaths and the result register. Depends on mls_pkg.
//
// Usage: grey pixels enter in raster order on the s_ stream, one per transaction,
// with their mask bit in s_tuser. Results leave on the m_ stream as (pixel, x, y);
// m_tlast marks the last result released by one input pixel, m_tuser flags the
// image's final pixel. Pixel (x,y) releases (x,y-1); on the last row it also
// releases (x-1,y), and at that row's end (x,y). Unless it is also the last, the first row releases nothing.
// An accepted pixel's operands are held in the window's stage register, its results
// in the result register that offers them on the m_ side. Throughput is one pixel
// per cycle while the m_ side is ready; on the last row of a multi-row image after its
// first column and at a single-row image's end the single output port sets the pace.
// The line buffer is 2 << $clog2(MAX_WIDTH) words of 9 bits in one memory with one write
// and two read ports; it needs no clearing pass and is ready right after reset.
// Reset (aresetn low at a clock edge) returns the raster position to (0,0),
// empties all stages and loads width 640, height 480, gain 128/256.
// A stalled m_ side holds its result; the input keeps accepting until the two
// internal stages are full, then s_tready drops. Configuration writes belong
// between images or while the block is empty.
module masked_laplacian_sharpen_unit #(
    parameter int MAX_WIDTH  = mls_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mls_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [mls_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mls_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // pixel input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mls_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] pixel_value
    input  logic [0:0]                        s_tuser,   // [0] in_mask
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mls_pkg::M_TDATA_W-1:0]     m_tdata,   // [7:0] out_pixel, [17:8] out_x,
                                                         // [27:18] out_y, [31:28] zero
    output logic                              m_tlast,   // last_of_run
    output logic [0:0]                        m_tuser    // [0] end_of_image
);
    import mls_pkg::*;

    logic [GEOM_W-1:0]   geom_cols_reg, geom_rows_reg;
    logic [AMOUNT_W-1:0] sharpen_amount_reg;

    logic        stage_valid, stage_ready;
    mls_bundle_t stage_bundle;
    mls_pixels_t pixels;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_cols_reg      <= RST_GEOM_COLS;
            geom_rows_reg      <= RST_GEOM_ROWS;
            sharpen_amount_reg <= RST_SHARPEN_AMOUNT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GEOM_COLS: begin
                    geom_cols_reg <= cfg_wdata[GEOM_W-1:0];
                end
                REG_GEOM_ROWS: begin
                    geom_rows_reg <= cfg_wdata[GEOM_W-1:0];
                end
                REG_SHARPEN_AMOUNT: begin
                    sharpen_amount_reg <= cfg_wdata[AMOUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mls_line_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_pixel     (s_tdata[PIX_W-1:0]),
        .in_mask      (s_tuser[0]),
        .geom_cols    (geom_cols_reg),
        .geom_rows    (geom_rows_reg),
        .stage_valid  (stage_valid),
        .stage_ready  (stage_ready),
        .stage_bundle (stage_bundle)
    );

    // one datapath per result slot
    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_sharpen
        mls_sharpen u_sharpen (
            .job    (stage_bundle.job[i]),
            .amount (sharpen_amount_reg),
            .pixel  (pixels[i])
        );
    end

    mls_result_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .stage_valid  (stage_valid),
        .stage_ready  (stage_ready),
        .stage_bundle (stage_bundle),
        .pixels       (pixels),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule

### src/mls_line_window.sv
// Raster counters, two-row line buffer and 3x3 neighbour window of the sharpening unit.
// Depends on mls_pkg; registers one operand bundle per accepted pixel.
`include "masked_laplacian_sharpen_unit_defines.svh"

module mls_line_window #(
    parameter int MAX_WIDTH  = mls_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mls_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mls_pkg::PIX_W-1:0]   in_pixel,
    input  logic                        in_mask,
    input  logic [mls_pkg::GEOM_W-1:0]  geom_cols,
    input  logic [mls_pkg::GEOM_W-1:0]  geom_rows,
    output logic                        stage_valid,
    input  logic                        stage_ready,
    output mls_pkg::mls_bundle_t        stage_bundle
);
    import mls_pkg::*;

    localparam int X_W   = $clog2(MAX_WIDTH);
    localparam int Y_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int W_W   = X_W + 1;
    localparam int H_W   = Y_W + 1;
    localparam int DEPTH = 2 << X_W;

    logic [X_W-1:0]     col_reg, col_next, col_next_inc;
    logic [Y_W-1:0]     row_reg, row_next;
    logic [W_W-1:0]     w_eff, x_inc;
    logic [H_W-1:0]     h_eff, y_inc;
    logic               row_end, last_row, x_ge1, x_ge2, y_ge1, y_ge2, x_lt_w, y_lt_h;
    logic               in_fire;
    logic [ENTRY_W-1:0] cur;

    // line buffer: row y lives in bank y[0]
    logic [ENTRY_W-1:0] line_mem [DEPTH];
    logic [X_W:0]       wr_addr, rd_prev_addr, rd_top_addr;
    logic [ENTRY_W-1:0] prev_rd_reg, top_rd_reg;

    // window over the previous row and the current row
    logic [ENTRY_W-1:0] win0_reg, win1_reg, first_reg, cur_d1_reg, cur_d2_reg;
    logic [ENTRY_W-1:0] p_m1, p_0, p_p1;

    mls_bundle_t bundle_next, stage_bundle_reg;
    logic        stage_valid_reg;

    function automatic logic [PIX_W-1:0] pick(input logic [ENTRY_W-1:0] entry,
                                              input logic in_img,
                                              input logic [PIX_W-1:0] center);
        return (in_img && entry[ENTRY_W-1]) ? entry[PIX_W-1:0] : center;
    endfunction

    assign cur      = {in_mask, in_pixel};
    assign in_ready = !stage_valid_reg || stage_ready;
    assign in_fire  = in_valid && in_ready;

    // effective geometry: zero counts as one, large values saturate
    always_comb begin
        if (geom_cols == '0) begin
            w_eff = W_W'(1);
        end else if (geom_cols > MAX_WIDTH) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(geom_cols);
        end
        if (geom_rows == '0) begin
            h_eff = H_W'(1);
        end else if (geom_rows > MAX_HEIGHT) begin
            h_eff = H_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_W'(geom_rows);
        end
    end

    // position flags of the pixel on the input
    assign x_inc    = {1'b0, col_reg} + W_W'(1);
    assign y_inc    = {1'b0, row_reg} + H_W'(1);
    assign row_end  = x_inc >= w_eff;
    assign last_row = y_inc >= h_eff;
    assign x_lt_w   = {1'b0, col_reg} < w_eff;
    assign y_lt_h   = {1'b0, row_reg} < h_eff;
    assign x_ge1    = col_reg != '0;
    assign x_ge2    = {1'b0, col_reg} >= W_W'(2);
    assign y_ge1    = row_reg != '0;
    assign y_ge2    = {1'b0, row_reg} >= H_W'(2);

    // raster position of the following pixel
    always_comb begin
        if (row_end) begin
            col_next = '0;
            row_next = last_row ? '0 : y_inc[Y_W-1:0];
        end else begin
            col_next = x_inc[X_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // write this pixel, fetch what the next one needs (write-first on a clash)
    assign col_next_inc = col_next + X_W'(1);
    assign wr_addr      = {row_reg[0], col_reg};
    assign rd_prev_addr = {~row_next[0], col_next_inc};
    assign rd_top_addr  = {row_next[0], col_next};

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            line_mem[wr_addr] <= cur;
            prev_rd_reg <= (rd_prev_addr == wr_addr) ? cur : line_mem[rd_prev_addr];
            top_rd_reg  <= (rd_top_addr == wr_addr) ? cur : line_mem[rd_top_addr];
        end
    end

    // previous-row taps at x-1, x, x+1
    assign p_p1 = prev_rd_reg;
    assign p_0  = x_ge1 ? win1_reg : first_reg;
    assign p_m1 = win0_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            win0_reg   <= p_0;
            win1_reg   <= p_p1;
            cur_d1_reg <= cur;
            cur_d2_reg <= cur_d1_reg;
            if (!x_ge1) begin
                first_reg <= cur;
            end
        end
    end

    // operands of the up to three results of this pixel
    always_comb begin
        bundle_next = '0;

        // (x, y-1): previous row, bottom is the input
        bundle_next.mask[SLOT_A]       = y_ge1;
        bundle_next.job[SLOT_A].center = p_0;
        bundle_next.job[SLOT_A].left   = pick(p_m1, x_ge1, p_0[PIX_W-1:0]);
        bundle_next.job[SLOT_A].right  = pick(p_p1, !row_end, p_0[PIX_W-1:0]);
        bundle_next.job[SLOT_A].top    = pick(top_rd_reg, y_ge2, p_0[PIX_W-1:0]);
        bundle_next.job[SLOT_A].bottom = pick(cur, y_lt_h && x_lt_w, p_0[PIX_W-1:0]);
        bundle_next.job[SLOT_A].x      = XY_W'(col_reg);
        bundle_next.job[SLOT_A].y      = XY_W'(row_reg - Y_W'(1));

        // (x-1, y) on the last row, bottom is the center
        bundle_next.mask[SLOT_B]       = last_row && x_ge1;
        bundle_next.job[SLOT_B].center = cur_d1_reg;
        bundle_next.job[SLOT_B].left   = pick(cur_d2_reg, x_ge2, cur_d1_reg[PIX_W-1:0]);
        bundle_next.job[SLOT_B].right  = pick(cur, x_lt_w, cur_d1_reg[PIX_W-1:0]);
        bundle_next.job[SLOT_B].top    = pick(p_m1, y_ge1, cur_d1_reg[PIX_W-1:0]);
        bundle_next.job[SLOT_B].bottom = cur_d1_reg[PIX_W-1:0];
        bundle_next.job[SLOT_B].x      = XY_W'(col_reg - X_W'(1));
        bundle_next.job[SLOT_B].y      = XY_W'(row_reg);

        // (x, y) at the end of the last row
        bundle_next.mask[SLOT_C]       = last_row && row_end;
        bundle_next.job[SLOT_C].center = cur;
        bundle_next.job[SLOT_C].left   = pick(cur_d1_reg, x_ge1, cur[PIX_W-1:0]);
        bundle_next.job[SLOT_C].right  = cur[PIX_W-1:0];
        bundle_next.job[SLOT_C].top    = pick(p_0, y_ge1, cur[PIX_W-1:0]);
        bundle_next.job[SLOT_C].bottom = cur[PIX_W-1:0];
        bundle_next.job[SLOT_C].x      = XY_W'(col_reg);
        bundle_next.job[SLOT_C].y      = XY_W'(row_reg);
    end

    // stage register toward the arithmetic
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (in_fire) begin
            stage_valid_reg <= 1'b1;
        end else if (stage_ready) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            stage_bundle_reg <= bundle_next;
        end
    end

    assign stage_valid  = stage_valid_reg;
    assign stage_bundle = stage_bundle_reg;

    `MLS_ASSERT_NEXT(a_col_wrap, in_fire && row_end, col_reg == '0)
    `MLS_ASSERT_NEXT(a_col_step, in_fire && !row_end, col_reg == $past(x_inc[X_W-1:0]))
    `MLS_ASSERT_NEXT(a_stage_hold, stage_valid && !stage_ready, stage_valid && $stable(stage_bundle))

endmodule

### src/mls_sharpen.sv
// Laplacian sharpening of one pixel: gain multiply, round half away from zero, clamp.
// Depends on mls_pkg for the operand bundle type.
module mls_sharpen (
    input  mls_pkg::mls_job_t              job,
    input  logic [mls_pkg::AMOUNT_W-1:0]   amount,
    output logic [mls_pkg::PIX_W-1:0]      pixel
);
    import mls_pkg::*;

    logic [PIX_W+1:0]   nb_sum;
    logic signed [10:0] lap;
    logic signed [23:0] prod;
    logic [24:0]        v, v_rnd;
    logic [16:0]        q;

    // 4*center minus the four neighbours
    assign nb_sum = (PIX_W + 2)'(job.left) + (PIX_W + 2)'(job.right)
                  + (PIX_W + 2)'(job.top) + (PIX_W + 2)'(job.bottom);
    assign lap    = $signed({1'b0, job.center[PIX_W-1:0], 2'b00}) - $signed({1'b0, nb_sum});
    assign prod   = $signed({1'b0, amount}) * lap;

    // 256*center + gain*laplacian, then round
    assign v      = {9'b0, job.center[PIX_W-1:0], 8'b0} + {prod[23], prod};
    assign v_rnd  = v + 25'd128;
    assign q      = v_rnd[24:8];

    always_comb begin
        if (!job.center[ENTRY_W-1]) begin
            pixel = job.center[PIX_W-1:0];
        end else if (v[24]) begin
            pixel = '0;                      // negative rounds to zero or below
        end else if (q > 17'd255) begin
            pixel = '1;
        end else begin
            pixel = q[PIX_W-1:0];
        end
    end

endmodule

### src/mls_result_out.sv
// Result register of the sharpening unit: holds up to three results of one pixel
// and hands them to the output stream one per transaction. Depends on mls_pkg.
`include "masked_laplacian_sharpen_unit_defines.svh"

module mls_result_out (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             stage_valid,
    output logic                             stage_ready,
    input  mls_pkg::mls_bundle_t             stage_bundle,
    input  mls_pkg::mls_pixels_t             pixels,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mls_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    output logic [0:0]                       m_tuser
);
    import mls_pkg::*;

    logic [NUM_SLOTS-1:0] pend_reg, pend_next, pend_left;
    mls_result_t          res_reg [NUM_SLOTS];
    mls_result_t          res_sel;
    logic [SLOT_W-1:0]    sel;
    logic                 fire, done, load_ok, load;

    // oldest pending slot goes first
    always_comb begin
        if (pend_reg[SLOT_A]) begin
            sel = SLOT_A;
        end else if (pend_reg[SLOT_B]) begin
            sel = SLOT_B;
        end else begin
            sel = SLOT_C;
        end
        pend_left      = pend_reg;
        pend_left[sel] = 1'b0;
    end

    assign fire        = m_tvalid && m_tready;
    assign done        = fire && (pend_left == '0);
    assign load_ok     = !m_tvalid || done;
    assign stage_ready = (stage_bundle.mask == '0) || load_ok;
    assign load        = stage_valid && load_ok && (stage_bundle.mask != '0);

    always_comb begin
        if (load) begin
            pend_next = stage_bundle.mask;
        end else if (fire) begin
            pend_next = pend_left;
        end else begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // result payload, loaded with the whole bundle
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                res_reg[i].pixel <= pixels[i];
                res_reg[i].x     <= stage_bundle.job[i].x;
                res_reg[i].y     <= stage_bundle.job[i].y;
            end
        end
    end

    assign res_sel  = res_reg[sel];
    assign m_tvalid = pend_reg != '0;
    assign m_tdata  = {{M_PAD_W{1'b0}}, res_sel.y, res_sel.x, res_sel.pixel};
    assign m_tlast  = pend_left == '0;
    assign m_tuser  = 1'(sel == SLOT_C);

    `MLS_ASSERT_IMPLIES(a_end_is_last, m_tvalid && m_tuser[0], m_tlast)
    `MLS_ASSERT_NEXT(a_rest_offered, fire && !m_tlast, m_tvalid)
    `MLS_ASSERT_NEXT(a_drain_empty, done && !load, !m_tvalid)

endmodule

### dv/masked_laplacian_sharpen_unit_tb.sv
// Self-checking testbench for the masked 3x3 Laplacian sharpening unit.
// Holds its own line-buffer predictor and a result scoreboard; needs mls_pkg and the RTL.
`timescale 1ns / 100ps

import mls_pkg::*;

// one expected output transaction
typedef struct {
    logic [PIX_W-1:0] level;
    logic [XY_W-1:0]  col;
    logic [XY_W-1:0]  row;
    logic             run_last;
    logic             frame_end;
} sharpened_pixel_t;

// predicts the block's results and checks the output stream against them
class sharpen_scoreboard;
    bit [ENTRY_W-1:0] line_store [2*DEF_MAX_WIDTH];
    int col_pos;
    int row_pos;
    int width_reg;
    int height_reg;
    int amount_reg;
    sharpened_pixel_t pending_results[$];
    sharpened_pixel_t batch[NUM_SLOTS];
    int batch_len;
    int mismatches;
    int checked;
    int frames_done;

    function new();
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = RST_GEOM_COLS;
        height_reg = RST_GEOM_ROWS;
        amount_reg = RST_SHARPEN_AMOUNT;
        mismatches = 0;
        checked    = 0;
        frames_done = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        case (index)
            REG_GEOM_COLS:      width_reg  = value[GEOM_W-1:0];
            REG_GEOM_ROWS:      height_reg = value[GEOM_W-1:0];
            REG_SHARPEN_AMOUNT: amount_reg = value[AMOUNT_W-1:0];
            default: ;
        endcase
    endfunction

    // outside or unmasked neighbors fall back to the center level
    function int neighbor(bit [ENTRY_W-1:0] entry, bit in_frame, int center);
        return (!in_frame || !entry[PIX_W]) ? center : int'(entry[PIX_W-1:0]);
    endfunction

    function logic [PIX_W-1:0] sharpen_level(bit [ENTRY_W-1:0] c, int l, int r, int t, int b);
        int cv;
        int lap;
        int v;
        int q;
        cv = c[PIX_W-1:0];
        if (!c[PIX_W])
            return c[PIX_W-1:0];
        lap = 4 * cv - l - r - t - b;
        v = cv * 256 + amount_reg * lap;
        // round half away from zero, then clamp
        q = (v >= 0) ? (v + 128) / 256 : -((128 - v) / 256);
        if (q < 0)
            q = 0;
        if (q > 255)
            q = 255;
        return q[PIX_W-1:0];
    endfunction

    function void add_result(logic [PIX_W-1:0] level, int x, int y, bit frame_end);
        batch[batch_len].level     = level;
        batch[batch_len].col       = x[XY_W-1:0];
        batch[batch_len].row       = y[XY_W-1:0];
        batch[batch_len].run_last  = 1'b0;
        batch[batch_len].frame_end = frame_end;
        batch_len++;
        if (frame_end)
            frames_done++;
    endfunction

    // an input pixel was accepted: advance the raster and queue what it releases
    function void note_pixel(logic [PIX_W-1:0] level, logic in_region);
        int w;
        int h;
        int x;
        int y;
        int bp;
        int bc;
        int cv;
        int l;
        int r;
        int t;
        bit [ENTRY_W-1:0] cur;
        bit [ENTRY_W-1:0] c;
        bit last_row;
        bit row_end;
        w = width_reg;
        h = height_reg;
        x = col_pos;
        y = row_pos;
        cur = {in_region, level};
        batch_len = 0;
        if (w == 0)
            w = 1;
        if (w > DEF_MAX_WIDTH)
            w = DEF_MAX_WIDTH;
        if (h == 0)
            h = 1;
        if (h > DEF_MAX_HEIGHT)
            h = DEF_MAX_HEIGHT;
        bp = ((y + 1) % 2) * DEF_MAX_WIDTH;
        bc = (y % 2) * DEF_MAX_WIDTH;
        last_row = (y >= h - 1);
        row_end  = (x >= w - 1);

        // pixel above the input
        if (y >= 1) begin
            c  = line_store[bp + x];
            cv = c[PIX_W-1:0];
            l  = neighbor(x >= 1 ? line_store[bp + x - 1] : '0, x >= 1, cv);
            r  = neighbor(x + 1 < w ? line_store[bp + x + 1] : '0, x + 1 < w, cv);
            t  = neighbor(line_store[bc + x], y >= 2, cv);
            add_result(sharpen_level(c, l, r, t, neighbor(cur, y < h && x < w, cv)),
                       x, y - 1, 1'b0);
        end

        line_store[bc + x] = cur;

        // last row: pixel left of the input
        if (last_row && x >= 1) begin
            c  = line_store[bc + x - 1];
            cv = c[PIX_W-1:0];
            l  = neighbor(x >= 2 ? line_store[bc + x - 2] : '0, x >= 2, cv);
            r  = neighbor(cur, x < w, cv);
            t  = neighbor(y >= 1 ? line_store[bp + x - 1] : '0, y >= 1, cv);
            add_result(sharpen_level(c, l, r, t, cv), x - 1, y, 1'b0);
        end

        // last row end: the input itself closes the image
        if (last_row && row_end) begin
            cv = level;
            l  = neighbor(x >= 1 ? line_store[bc + x - 1] : '0, x >= 1, cv);
            t  = neighbor(y >= 1 ? line_store[bp + x] : '0, y >= 1, cv);
            add_result(sharpen_level(cur, l, cv, t, cv), x, y, 1'b1);
        end

        for (int i = 0; i < batch_len; i++) begin
            batch[i].run_last = (i == batch_len - 1);
            pending_results.push_back(batch[i]);
        end

        if (row_end) begin
            col_pos = 0;
            row_pos = last_row ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
        end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("mismatch in %s at result %0d: expected %0d, got %0d",
                         field, checked, want, got);
            mismatches++;
        end
    endfunction

    // an output transaction was accepted: compare with the oldest expectation
    function void check_result(logic [M_TDATA_W-1:0] tdata, logic tlast, logic frame_end);
        sharpened_pixel_t want;
        if (pending_results.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: pixel %0d at (%0d,%0d)",
                         tdata[7:0], tdata[17:8], tdata[27:18]);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        compare("out_pixel", want.level, tdata[7:0]);
        compare("out_x", want.col, tdata[17:8]);
        compare("out_y", want.row, tdata[27:18]);
        compare("last_of_run", want.run_last, tlast);
        compare("end_of_image", want.frame_end, frame_end);
        checked++;
    endfunction
endclass

module masked_laplacian_sharpen_unit_tb;

    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 50000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pixels_sent    = 0;
    int broken_frames  = 0;

    sharpen_scoreboard sb;

    masked_laplacian_sharpen_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // random backpressure on the result side
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast, m_tuser[0]);
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("timeout: %0d results still expected", sb.pending_results.size());
        $display("masked_laplacian_sharpen_unit regression: fail");
        $finish;
    end

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    // one pixel transaction; valid stays high unless the next call idles
    task automatic send_pixel(input logic [PIX_W-1:0] level, input logic in_region);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= level;
        s_tuser  <= in_region;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(level, in_region);
        pixels_sent++;
    endtask

    // stop sending until every expected result is out and the pipe has settled
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index, input int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        sb.write_reg(index, value[CFG_DATA_W-1:0]);
        @(posedge aclk);
    endtask

    task automatic set_geometry(input int w, input int h, input int amount);
        write_reg(REG_GEOM_COLS, w);
        write_reg(REG_GEOM_ROWS, h);
        write_reg(REG_SHARPEN_AMOUNT, amount);
        cfg_wr_en <= 1'b0;
    endtask

    // random pixels until the raster wraps back to the image origin
    task automatic send_frame(input int mask_pct, input int extreme_pct);
        logic [PIX_W-1:0] level;
        do begin
            if ($urandom_range(99) < extreme_pct)
                level = $urandom_range(1) ? 8'hff : 8'h00;
            else
                level = $urandom_range(255);
            send_pixel(level, $urandom_range(99) < mask_pct);
        end while (sb.col_pos != 0 || sb.row_pos != 0);
    endtask

    function automatic int random_gain();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 4095;
            2:       return $urandom_range(512);
            default: return $urandom_range(4095);
        endcase
    endfunction

    initial begin
        int w;
        int h;
        int gain;
        int start_count;
        int cut;
        int waited;

        sb = new();
        set_idling(30, 71);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // checkerboard 3x3 at the reset gain: clamping and half rounding
        write_reg(REG_GEOM_COLS, 3);
        write_reg(REG_GEOM_ROWS, 3);
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2 == 0) ? 8'hff : 8'h00, (i != 2) && (i != 6));

        // zero width read as one column, full gain
        hold_until_drained();
        set_geometry(0, 2, 4095);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hff, 1'b1);

        // single-row image with zero gain
        hold_until_drained();
        set_geometry(4, 1, 0);
        send_pixel(8'h80, 1'b1);
        send_pixel(8'h01, 1'b1);
        send_pixel(8'hfe, 1'b0);
        send_pixel(8'h7f, 1'b1);

        // geometry shrunk in the middle of an image
        hold_until_drained();
        set_geometry(4, 4, 384);
        for (int i = 0; i < 6; i++)
            send_pixel($urandom_range(255), 1'b1);
        hold_until_drained();
        set_geometry(2, 2, 384);
        send_frame(100, 20);

        // extreme geometry: saturated width, saturated height, zero height
        set_idling(71, 30);
        hold_until_drained();
        set_geometry(2047, 2, random_gain());
        for (int i = 0; i < 6; i++)
            send_pixel($urandom_range(255), $urandom_range(4) != 0);
        hold_until_drained();
        set_geometry(2, 2, random_gain());
        send_frame(80, 20);
        hold_until_drained();
        set_geometry(1, 2047, 4095);
        for (int i = 0; i < 4; i++)
            send_pixel($urandom_range(255), $urandom_range(4) != 0);
        hold_until_drained();
        set_geometry(1, 2, 4095);
        send_frame(80, 20);
        hold_until_drained();
        set_geometry(5, 0, 0);
        send_frame(80, 20);

        // random small images, some cut short by a geometry change
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_ITEMS) begin
            if (pixels_sent - start_count < RANDOM_ITEMS / 2)
                set_idling(71, 30);
            else
                set_idling(0, 0);
            w = $urandom_range(9);
            h = $urandom_range(5);
            gain = random_gain();
            hold_until_drained();
            set_geometry(w, h, gain);
            if ($urandom_range(7) == 0 && w * h >= 2) begin
                cut = $urandom_range(w * h - 1, 1);
                for (int i = 0; i < cut; i++)
                    send_pixel($urandom_range(255), $urandom_range(3) != 0);
                hold_until_drained();
                set_geometry($urandom_range(w), $urandom_range(h), random_gain());
                broken_frames++;
            end
            send_frame($urandom_range(3) == 0 ? $urandom_range(100) : 85, 15);
        end

        // drain and let the pipe settle
        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d pixels in %0d images (%0d cut short), %0d results checked",
                 pixels_sent, sb.frames_done, broken_frames, sb.checked);
        $display("gains 0 to 4095, widths and heights from zero up to saturation");
        if (sb.pending_results.size() != 0)
            $display("%0d expected results never arrived", sb.pending_results.size());
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("masked_laplacian_sharpen_unit regression: pass");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("masked_laplacian_sharpen_unit regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/mls_pkg.sv
src/mls_line_window.sv
src/mls_sharpen.sv
src/mls_result_out.sv
src/masked_laplacian_sharpen_unit.sv
dv/masked_laplacian_sharpen_unit_tb.sv
